/* rtl/core/rv32ia_pkg.sv */
`default_nettype none
package rv32ia_pkg;

	// Fixed field widths of one instruction and one result
	localparam int unsigned OP_W      = 4;
	localparam int unsigned REG_IDX_W = 5;
	localparam int unsigned IMM_W     = 12;
	localparam int unsigned XLEN      = 32;
	localparam int unsigned SHAMT_W   = 5;

	// Stream payload widths, packed from the lowest bit, padded to whole bytes
	localparam int unsigned IN_FIELDS_W  = OP_W + 2 * REG_IDX_W + IMM_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = REG_IDX_W + XLEN;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Immediate-form ALU operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADDI  = 4'd0,
		OP_SLTI  = 4'd1,
		OP_SLTIU = 4'd2,
		OP_XORI  = 4'd3,
		OP_ORI   = 4'd4,
		OP_ANDI  = 4'd5,
		OP_SLLI  = 4'd6,
		OP_SRLI  = 4'd7,
		OP_SRAI  = 4'd8
	} op_t;

	// Register file write port
	typedef struct packed {
		logic                 en;
		logic [REG_IDX_W-1:0] addr;
		logic [XLEN-1:0]      data;
	} rf_wr_t;

endpackage
`default_nettype wire

/* rtl/core/rv32ia_alu.sv */
`default_nettype none
module rv32ia_alu (
	input  wire  rv32ia_pkg::op_t                 op,
	input  wire  logic [rv32ia_pkg::XLEN-1:0]     src_val,
	input  wire  logic [rv32ia_pkg::IMM_W-1:0]    imm,
	output logic [rv32ia_pkg::XLEN-1:0]           result,
	output logic                                  op_ok
);
	import rv32ia_pkg::*;

	logic [XLEN-1:0]    imm_sx;
	logic [SHAMT_W-1:0] shamt;

	assign imm_sx = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
	assign shamt  = imm[SHAMT_W-1:0];

	// Operation select; undefined codes flag op_ok low
	always_comb begin
		result = '0;
		op_ok  = 1'b1;
		unique case (op)
			OP_ADDI:  result = src_val + imm_sx;
			OP_SLTI:  result = XLEN'($signed(src_val) < $signed(imm_sx));
			OP_SLTIU: result = XLEN'(src_val < imm_sx);
			OP_XORI:  result = src_val ^ imm_sx;
			OP_ORI:   result = src_val | imm_sx;
			OP_ANDI:  result = src_val & imm_sx;
			OP_SLLI:  result = src_val << shamt;
			OP_SRLI:  result = src_val >> shamt;
			OP_SRAI:  result = $unsigned($signed(src_val) >>> shamt);
			default:  op_ok  = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/rv32ia_regfile.sv */
`default_nettype none
module rv32ia_regfile #(
	parameter int unsigned NUM_REGS = 32
) (
	input  wire  logic                              clk,
	input  wire  logic                              arst_n,
	input  wire  logic                              rd_en,
	input  wire  logic [rv32ia_pkg::REG_IDX_W-1:0]  rd_addr,
	output logic [rv32ia_pkg::XLEN-1:0]             rd_data,
	input  wire  rv32ia_pkg::rf_wr_t                wr
);
	import rv32ia_pkg::*;

	localparam int unsigned AW = $clog2(NUM_REGS);

	logic [XLEN-1:0]     mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [XLEN-1:0]     mem_rd_q;
	logic                rd_zero_q;
	logic                fwd_q;
	logic [XLEN-1:0]     fwd_data_q;
	logic                rd_in_range;
	logic                rd_zero;
	logic                rd_fwd;

	// x0 and indexes beyond the file read as zero
	assign rd_in_range = (32'(rd_addr) < 32'(NUM_REGS));
	assign rd_zero     = (rd_addr == '0) || !rd_in_range || !valid_q[rd_addr[AW-1:0]];
	// a write landing on the same edge as the read is forwarded
	assign rd_fwd      = wr.en && (wr.addr == rd_addr);

	// Storage and synchronous read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr[AW-1:0]];
			fwd_data_q <= wr.data;
		end
	end

	// Per-entry written flags stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_zero_q <= 1'b1;
			fwd_q     <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rd_zero_q <= rd_zero;
				fwd_q     <= rd_fwd;
			end
		end
	end

	always_comb begin
		priority if (fwd_q) begin
			rd_data = fwd_data_q;
		end else if (rd_zero_q) begin
			rd_data = '0;
		end else begin
			rd_data = mem_rd_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/rv32ia_regfile_core.sv */
`default_nettype none
module rv32ia_regfile_core #(
	parameter int unsigned NUM_REGS = 32
) (
	input  wire  logic                                clk,
	input  wire  logic                                arst_n,
	input  wire  logic                                in_fire,
	input  wire  logic [rv32ia_pkg::IN_TDATA_W-1:0]   in_data,
	input  wire  logic                                s1_fire,
	output logic                                      s1_valid,
	output logic [rv32ia_pkg::REG_IDX_W-1:0]          res_reg,
	output logic [rv32ia_pkg::XLEN-1:0]               res_val
);
	import rv32ia_pkg::*;

	logic [OP_W-1:0]      in_op;
	logic [REG_IDX_W-1:0] in_dest;
	logic [REG_IDX_W-1:0] in_src;
	logic [IMM_W-1:0]     in_imm;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [REG_IDX_W-1:0] dest_s1;
	logic [IMM_W-1:0]     imm_s1;

	logic [XLEN-1:0]      src_val;
	logic [XLEN-1:0]      alu_res;
	logic                 alu_ok;
	logic                 dest_ok;
	rf_wr_t               rf_wr;

	assign in_op   = in_data[OP_W-1:0];
	assign in_dest = in_data[OP_W +: REG_IDX_W];
	assign in_src  = in_data[OP_W+REG_IDX_W +: REG_IDX_W];
	assign in_imm  = in_data[OP_W+2*REG_IDX_W +: IMM_W];

	// Execute stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Execute stage payload, loaded alongside the register read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op_t'(in_op);
			dest_s1 <= in_dest;
			imm_s1  <= in_imm;
		end
	end

	rv32ia_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (in_src),
		.rd_data (src_val),
		.wr      (rf_wr)
	);

	rv32ia_alu u_alu (
		.op      (op_s1),
		.src_val (src_val),
		.imm     (imm_s1),
		.result  (alu_res),
		.op_ok   (alu_ok)
	);

	// Write back when the stage retires; x0 and out-of-range writes drop
	assign dest_ok    = (dest_s1 != '0) && (32'(dest_s1) < 32'(NUM_REGS));
	assign rf_wr.en   = s1_fire && alu_ok && dest_ok;
	assign rf_wr.addr = dest_s1;
	assign rf_wr.data = alu_res;

	assign s1_valid = valid_s1;
	assign res_reg  = alu_ok ? dest_s1 : '0;
	assign res_val  = (alu_ok && dest_ok) ? alu_res : '0;

endmodule
`default_nettype wire

/* rtl/core/rv32_itype_alu_regfile_core.sv */
// RV32I immediate-form ALU (ADDI..SRAI) with a private register file.
// Input channel s_axis: one decoded instruction per transaction; tdata holds
// req_type, dest_reg, src_reg and immediate from the lowest bit up.
// Output channel m_axis: exactly one transaction per instruction, carrying
// the destination index and the value it now holds (0 for x0, for indexes
// at or above NUM_REGS, and both fields 0 for an undefined req_type).
// Pipeline: an input transaction loads the execute stage together with the
// synchronous register file read; the execute stage then writes back and
// loads the output register, which drives m_axis_tvalid.
// Throughput: one instruction per cycle while the output is not stalled; a
// write is forwarded to a read of the same register issued on the same edge,
// so dependent instructions issue back to back.
// Reset: all registers read zero right after arst_n releases; per-entry
// written flags cover the array, so no clearing pass is needed.
// Stall: while m_axis_tready is low the output register holds its
// transaction, the execute stage keeps one more, and s_axis_tready drops
// only once both are full.
`default_nettype none
module rv32_itype_alu_regfile_core #(
	parameter int unsigned NUM_REGS = 32
) (
	input  wire  logic                                 clk,
	input  wire  logic                                 arst_n,
	input  wire  logic                                 s_axis_tvalid,
	output logic                                       s_axis_tready,
	// req_type[3:0], dest_reg[8:4], src_reg[13:9], immediate[25:14], zero pad
	input  wire  logic [rv32ia_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  wire  logic                                 m_axis_tready,
	// written_reg[4:0], written_value[36:5], zero pad
	output logic [rv32ia_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
	import rv32ia_pkg::*;

	logic                 in_fire;
	logic                 s1_valid;
	logic                 s1_fire;
	logic                 out_free;
	logic [REG_IDX_W-1:0] res_reg;
	logic [XLEN-1:0]      res_val;

	logic                 m_valid_q;
	logic [REG_IDX_W-1:0] m_reg_q;
	logic [XLEN-1:0]      m_val_q;

	// Handshake: the output register frees when empty or taken this cycle
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s1_fire       = s1_valid && out_free;
	assign s_axis_tready = !s1_valid || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	rv32ia_regfile_core #(
		.NUM_REGS(NUM_REGS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_data  (s_axis_tdata),
		.s1_fire  (s1_fire),
		.s1_valid (s1_valid),
		.res_reg  (res_reg),
		.res_val  (res_val)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= s1_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_reg_q <= res_reg;
			m_val_q <= res_val;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({m_val_q, m_reg_q});

endmodule
`default_nettype wire
